>>> rtl/core/assert_macros.svh
// Assertion macros shared by the box average downscaler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/boxavg_pkg.sv
// Shared types and constants for the box average downscaler.
package boxavg_pkg;

    localparam int PIXEL_OUT_W  = 8;
    localparam int FACTOR_REG_W = 5;
    localparam int DIM_REG_W    = 11;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_INDEX_W  = 2;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    localparam t_cfg_index CFG_FACTOR = 2'd0;
    localparam t_cfg_index CFG_WIDTH  = 2'd1;
    localparam t_cfg_index CFG_HEIGHT = 2'd2;

    localparam logic [FACTOR_REG_W-1:0] RST_FACTOR = 5'd1;
    localparam logic [DIM_REG_W-1:0]    RST_WIDTH  = 11'd1024;
    localparam logic [DIM_REG_W-1:0]    RST_HEIGHT = 11'd1024;

    // Operand selection for the shared divider.
    typedef logic [1:0] t_div_sel;
    localparam t_div_sel DIV_SEL_WIDTH  = 2'd0;
    localparam t_div_sel DIV_SEL_HEIGHT = 2'd1;
    localparam t_div_sel DIV_SEL_AVG    = 2'd2;

    typedef struct packed {
        logic     accept;     // input item taken this cycle
        logic     sum;        // add running sum into line store entry
        logic     div_start;
        t_div_sel div_sel;
        logic     latch_w;    // capture width remainder
        logic     latch_h;    // capture height remainder, update size flag
        logic     out_div;    // load quotient into output register
    } t_dp_cmd;

    typedef struct packed {
        logic cfg_wr;     // register write taken this cycle
        logic need_mem;   // current input closes a block column span
        logic emit;       // pending block sum finishes a block
        logic div_done;
        logic out_free;   // output register can take a new item
    } t_dp_sts;

endpackage

>>> rtl/core/box_average_downscaler.sv
// Top level of the box average downscaler.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+-----------------------------------------
//  pixel in  | i_valid / o_stall           | i_pixel_in
//  pixel out | o_valid / i_stall           | o_pixel_out, o_frame_end, o_size_error
//  config    | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One item per cycle while the output is free: with factor one, for a size error,
// and inside a block row span. The pixel that ends a block column span adds a line
// store read, then an update. A pixel that completes a block adds the iterative
// divide, one quotient bit per cycle for DW bits, DW = max(PB + 2 * FB, 11, WB) (18
// by default). Each register write reruns the size check, two divides with o_stall
// high. Reset is synchronous; the line store is not cleared. A stalled output holds
// the next result in the input sequencer until the output register frees.
`include "assert_macros.svh"

module box_average_downscaler #(
    parameter int PIXEL_BITS = 8,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_FACTOR = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [boxavg_pkg::PIXEL_OUT_W-1:0]  i_pixel_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [boxavg_pkg::PIXEL_OUT_W-1:0]  o_pixel_out,
    output logic                                o_frame_end,
    output logic                                o_size_error,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [boxavg_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [boxavg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import boxavg_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    boxavg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    boxavg_datapath #(
        .PIXEL_BITS (PIXEL_BITS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_pixel_in   (i_pixel_in),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_stall  (i_stall),
        .o_out_valid  (o_valid),
        .o_pixel_out  (o_pixel_out),
        .o_frame_end  (o_frame_end),
        .o_size_error (o_size_error)
    );

    `ASSERT_IMPLIES(a_error_item_shape, i_clk, i_rst_n, o_valid && o_size_error, o_pixel_out == '0 && o_frame_end)

endmodule

>>> rtl/core/boxavg_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`include "assert_macros.svh"

module boxavg_div #(
    parameter int DW = 18,
    parameter int VW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic [DW-1:0] o_quo,
    output logic [VW-1:0] o_rem,
    output logic          o_done
);

    localparam int CNTW = $clog2(DW);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_quo;
    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_div;

    logic [VW:0]     trial;
    logic [VW:0]     diff;
    logic            ge;

    assign trial = {r_rem, r_quo[DW-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNTW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
    assign o_done = r_done;

    `ASSERT_IMPLIES(a_rem_below_divisor, i_clk, i_rst_n, r_done, r_rem < r_div)

endmodule

>>> rtl/core/boxavg_ctrl.sv
// Sequencer: input handshake, line store update, divide and size check steps.
`include "assert_macros.svh"

module boxavg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  boxavg_pkg::t_dp_sts i_sts,
    output boxavg_pkg::t_dp_cmd o_cmd
);

    import boxavg_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LOAD    = 4'd1;
    localparam logic [3:0] S_SUM     = 4'd2;
    localparam logic [3:0] S_DIV     = 4'd3;
    localparam logic [3:0] S_OUT     = 4'd4;
    localparam logic [3:0] S_CHKW_GO = 4'd5;
    localparam logic [3:0] S_CHKW    = 4'd6;
    localparam logic [3:0] S_CHKH_GO = 4'd7;
    localparam logic [3:0] S_CHKH    = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall   = !i_sts.out_free;
                o_cmd.accept = i_in_valid && i_sts.out_free;
                if (o_cmd.accept && i_sts.need_mem) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum     = 1'b1;
                o_cmd.div_sel = DIV_SEL_AVG;
                if (i_sts.emit) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_div = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_CHKW_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SEL_WIDTH;
                n_state         = S_CHKW;
            end
            S_CHKW: begin
                if (i_sts.div_done) begin
                    o_cmd.latch_w = 1'b1;
                    n_state       = S_CHKH_GO;
                end
            end
            S_CHKH_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SEL_HEIGHT;
                n_state         = S_CHKH;
            end
            S_CHKH: begin
                if (i_sts.div_done) begin
                    o_cmd.latch_h = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // any register write restarts the divisibility check
        if (i_sts.cfg_wr) begin
            n_state = S_CHKW_GO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_NEXT(a_load_to_sum, i_clk, i_rst_n, r_state == S_LOAD && !i_sts.cfg_wr, r_state == S_SUM)

endmodule

>>> rtl/core/boxavg_datapath.sv
// Datapath: settings, raster counters, running sum, line store, output register.
module boxavg_datapath #(
    parameter int PIXEL_BITS = 8,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_FACTOR = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [boxavg_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [boxavg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [boxavg_pkg::PIXEL_OUT_W-1:0]  i_pixel_in,
    input  boxavg_pkg::t_dp_cmd                 i_cmd,
    output boxavg_pkg::t_dp_sts                 o_sts,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [boxavg_pkg::PIXEL_OUT_W-1:0]  o_pixel_out,
    output logic                                o_frame_end,
    output logic                                o_size_error
);

    import boxavg_pkg::*;

    localparam int PB  = (PIXEL_BITS < PIXEL_OUT_W) ? PIXEL_BITS : PIXEL_OUT_W;
    localparam int FB  = $clog2(MAX_FACTOR + 1);
    localparam int IBW = $clog2(MAX_FACTOR);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WB  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = PB + FB;
    localparam int TW  = PB + 2 * FB;
    localparam int VW  = 2 * FB;
    localparam int DW0 = (TW > DIM_REG_W) ? TW : DIM_REG_W;
    localparam int DW  = (DW0 > WB) ? DW0 : WB;

    // settings
    logic [FACTOR_REG_W-1:0] r_factor;
    logic [DIM_REG_W-1:0]    r_width;
    logic [DIM_REG_W-1:0]    r_height;
    logic                    cfg_wr;

    logic [FB-1:0]           f_eff;
    logic [VW-1:0]           ff;
    logic [WB-1:0]           w_eff;
    logic [CW-1:0]           wlast;
    logic [DIM_REG_W-1:0]    h_eff;
    logic [DIM_REG_W-1:0]    hlast;

    // frame position
    logic [CW-1:0]           r_col;
    logic [DIM_REG_W-1:0]    r_row;
    logic [IBW-1:0]          r_cib;
    logic [IBW-1:0]          r_rib;
    logic [CW-1:0]           r_bcol;
    logic [RW-1:0]           r_run;
    logic [RW-1:0]           n_run;

    logic                    r_wok;
    logic                    r_size_ok;

    logic                    last_col;
    logic                    last_row;
    logic                    last_pix;
    logic                    mode_pass;
    logic                    mode_avg;
    logic                    mode_err;
    logic                    cib_last;
    logic                    cib_wrap;
    logic                    rib_wrap;
    logic [PB-1:0]           pix;

    // pending block column
    logic [CW-1:0]           r_addr;
    logic                    r_first;
    logic                    r_emit;
    logic                    r_last;
    logic [TW-1:0]           r_col_sums [MAX_WIDTH];
    logic [TW-1:0]           r_mem_q;
    logic [TW-1:0]           n_total;

    // divider
    logic [DW-1:0]           div_dividend;
    logic [VW-1:0]           div_divisor;
    logic [DW-1:0]           div_quo;
    logic [VW-1:0]           div_rem;
    logic                    div_done;

    // output register
    logic                    r_out_valid;
    logic [PIXEL_OUT_W-1:0]  r_out_pix;
    logic                    r_out_end;
    logic                    r_out_err;
    logic                    out_free;
    logic                    out_from_acc;
    logic [PIXEL_OUT_W-1:0]  n_out_pix;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && ((i_cfg_index == CFG_FACTOR) ||
                         (i_cfg_index == CFG_WIDTH) || (i_cfg_index == CFG_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= RST_FACTOR;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FACTOR: r_factor <= i_cfg_data[FACTOR_REG_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data[DIM_REG_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[DIM_REG_W-1:0];
                default:    r_factor <= r_factor;
            endcase
        end
    end

    // effective settings: zero reads as one, factor and width saturate
    always_comb begin
        if (r_factor == '0) begin
            f_eff = FB'(1);
        end else if (32'(r_factor) > MAX_FACTOR) begin
            f_eff = FB'(MAX_FACTOR);
        end else begin
            f_eff = FB'(r_factor);
        end
        if (r_width == '0) begin
            w_eff = WB'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = WB'(r_width);
        end
        h_eff = (r_height == '0) ? DIM_REG_W'(1) : r_height;
    end

    assign ff    = VW'(f_eff) * VW'(f_eff);
    assign wlast = CW'(w_eff - WB'(1));
    assign hlast = h_eff - DIM_REG_W'(1);

    assign pix       = i_pixel_in[PB-1:0];
    assign last_col  = (r_col >= wlast);
    assign last_row  = (r_row >= hlast);
    assign last_pix  = last_col && last_row;
    assign mode_pass = (f_eff == FB'(1));
    assign mode_avg  = !mode_pass && r_size_ok;
    assign mode_err  = !mode_pass && !r_size_ok;
    assign cib_last  = (FB'(r_cib) == f_eff - FB'(1));
    assign cib_wrap  = (FB'(r_cib) + FB'(1) >= f_eff);
    assign rib_wrap  = (FB'(r_rib) + FB'(1) >= f_eff);
    assign n_run     = ((r_cib == '0) ? '0 : r_run) + RW'(pix);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_col  <= '0;
            r_row  <= '0;
            r_cib  <= '0;
            r_rib  <= '0;
            r_bcol <= '0;
            r_run  <= '0;
        end else if (i_cmd.accept) begin
            if (mode_avg) begin
                r_run <= n_run;
            end
            if (last_col) begin
                r_col  <= '0;
                r_cib  <= '0;
                r_bcol <= '0;
                if (last_row) begin
                    r_row <= '0;
                    r_rib <= '0;
                end else begin
                    r_row <= r_row + DIM_REG_W'(1);
                    r_rib <= rib_wrap ? '0 : r_rib + IBW'(1);
                end
            end else begin
                r_col <= r_col + CW'(1);
                r_cib <= cib_wrap ? '0 : r_cib + IBW'(1);
                if (cib_wrap) begin
                    r_bcol <= r_bcol + CW'(1);
                end
            end
        end
    end

    // capture what the line store update needs before the counters move on
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && mode_avg && cib_last) begin
            r_addr  <= r_bcol;
            r_first <= (r_rib == '0);
            r_emit  <= (FB'(r_rib) == f_eff - FB'(1));
            r_last  <= last_pix;
        end
    end

    assign n_total = (r_first ? '0 : r_mem_q) + TW'(r_run);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_col_sums[r_addr] <= n_total;
        end
        r_mem_q <= r_col_sums[r_addr];
    end

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_SEL_WIDTH: begin
                div_dividend = DW'(w_eff);
                div_divisor  = VW'(f_eff);
            end
            DIV_SEL_HEIGHT: begin
                div_dividend = DW'(h_eff);
                div_divisor  = VW'(f_eff);
            end
            DIV_SEL_AVG: begin
                div_dividend = DW'(n_total);
                div_divisor  = ff;
            end
            default: begin
                div_dividend = DW'(n_total);
                div_divisor  = ff;
            end
        endcase
    end

    boxavg_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quo      (div_quo),
        .o_rem      (div_rem),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wok     <= 1'b1;
            r_size_ok <= 1'b1;
        end else begin
            if (i_cmd.latch_w) begin
                r_wok <= (div_rem == '0);
            end
            if (i_cmd.latch_h) begin
                r_size_ok <= r_wok && (div_rem == '0);
            end
        end
    end

    assign out_free     = !r_out_valid || !i_out_stall;
    assign out_from_acc = i_cmd.accept && (mode_pass || (mode_err && last_pix));

    always_comb begin
        n_out_pix = '0;
        if (i_cmd.out_div) begin
            n_out_pix[PB-1:0] = div_quo[PB-1:0];
        end else if (mode_pass) begin
            n_out_pix[PB-1:0] = pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_div || out_from_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_div) begin
            r_out_pix <= n_out_pix;
            r_out_end <= r_last;
            r_out_err <= 1'b0;
        end else if (out_from_acc) begin
            r_out_pix <= n_out_pix;
            r_out_end <= last_pix;
            r_out_err <= mode_err;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_out_pix;
    assign o_frame_end  = r_out_end;
    assign o_size_error = r_out_err;

    assign o_sts.cfg_wr   = cfg_wr;
    assign o_sts.need_mem = mode_avg && cib_last;
    assign o_sts.emit     = r_emit;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = out_free;

endmodule
